@@ rtl/core/gpc_pkg.sv @@
package gpc_pkg;

  localparam int unsigned DEAD_W   = 16;
  localparam int unsigned PRESS_W  = 24;
  localparam int unsigned PRE_W    = 24;
  localparam int unsigned SEC_W    = 10;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned CFG_IDXW = 3;

  localparam logic [DEAD_W-1:0]  DEAD_TIME_RST  = DEAD_W'(1000);
  localparam logic [PRESS_W-1:0] LONG_PRESS_RST = PRESS_W'(2000000);
  localparam logic [PRE_W-1:0]   TPS_RST        = PRE_W'(1000000);
  localparam logic [SEC_W-1:0]   GATE_RST       = SEC_W'(10);
  localparam logic [CNT_W-1:0]   LIMIT_RST      = CNT_W'(9999);
  localparam logic [SEC_W-1:0]   SECONDS_MAX    = SEC_W'(999);

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_DEAD_TIME  = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_TPS        = 3'd2,
    CFG_GATE       = 3'd3,
    CFG_LIMIT      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DEAD_W-1:0]  dead_time_ticks;
    logic [PRESS_W-1:0] long_press_ticks;
    logic [PRE_W-1:0]   ticks_per_second;
    logic [SEC_W-1:0]   gate_seconds;
    logic [CNT_W-1:0]   count_limit;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] pulse_count;
    logic [SEC_W-1:0] seconds_shown;
    logic             is_running;
    logic             report_valid;
    logic [CNT_W-1:0] report_count;
  } res_t;

endpackage

@@ rtl/core/gpc_in_if.sv @@
interface gpc_in_if;
  logic valid;
  logic ready;
  logic pulse_rise;
  logic button_level;

  modport source (output valid, output pulse_rise, output button_level, input ready);
  modport sink   (input valid, input pulse_rise, input button_level, output ready);
endinterface

@@ rtl/core/gpc_out_if.sv @@
interface gpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [gpc_pkg::CNT_W-1:0]  pulse_count;
  logic [gpc_pkg::SEC_W-1:0]  seconds_shown;
  logic                       is_running;
  logic                       report_valid;
  logic [gpc_pkg::CNT_W-1:0]  report_count;

  modport source (output valid, output pulse_count, output seconds_shown,
                  output is_running, output report_valid, output report_count,
                  input ready);
  modport sink   (input valid, input pulse_count, input seconds_shown,
                  input is_running, input report_valid, input report_count,
                  output ready);
endinterface

@@ rtl/core/gated_pulse_counter_dead_time.sv @@
// Gated pulse counter with dead time. Each input word is one time tick and
// yields exactly one result word: the count and seconds of the current window,
// the run flag, and a report flag with the finished window's count. A new word
// is taken every clock cycle; its result is registered in the output register
// on acceptance. The only thing that slows intake is the single output
// register: while it holds a word the sink has not taken, input ready is low.
// The user must write cfg registers only while idle; the block does not check.
module gated_pulse_counter_dead_time (
  input  logic                          clk,
  input  logic                          rst_n,
  gpc_in_if.sink                        in_word,
  gpc_out_if.source                     out_word,
  input  logic                          cfg_we,
  input  logic [gpc_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [gpc_pkg::CFG_DW-1:0]    cfg_wdata
);
  import gpc_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic accept;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  gpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gpc_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .pulse_rise   (in_word.pulse_rise),
    .button_level (in_word.button_level),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.pulse_count   = res_r.pulse_count;
  assign out_word.seconds_shown = res_r.seconds_shown;
  assign out_word.is_running    = res_r.is_running;
  assign out_word.report_valid  = res_r.report_valid;
  assign out_word.report_count  = res_r.report_count;

endmodule

@@ rtl/core/gpc_cfg.sv @@
module gpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gpc_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [gpc_pkg::CFG_DW-1:0]    cfg_wdata,
  output gpc_pkg::cfg_t                 cfg
);
  import gpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEAD_TIME:  cfg_nxt.dead_time_ticks  = cfg_wdata[DEAD_W-1:0];
        CFG_LONG_PRESS: cfg_nxt.long_press_ticks = cfg_wdata[PRESS_W-1:0];
        CFG_TPS:        cfg_nxt.ticks_per_second = cfg_wdata[PRE_W-1:0];
        CFG_GATE:       cfg_nxt.gate_seconds     = cfg_wdata[SEC_W-1:0];
        CFG_LIMIT:      cfg_nxt.count_limit      = cfg_wdata[CNT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_time_ticks  <= DEAD_TIME_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.ticks_per_second <= TPS_RST;
      cfg_r.gate_seconds     <= GATE_RST;
      cfg_r.count_limit      <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/gpc_core.sv @@
module gpc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  logic           pulse_rise,
  input  logic           button_level,
  input  gpc_pkg::cfg_t  cfg,
  output gpc_pkg::res_t  res
);
  import gpc_pkg::*;

  logic [DEAD_W-1:0]  since_r,  since_nxt;
  logic [CNT_W-1:0]   total_r,  total_nxt;
  logic               run_r,    run_nxt;
  logic [PRE_W-1:0]   pre_r,    pre_nxt;
  logic [SEC_W-1:0]   secs_r,   secs_nxt;
  logic               was_r,    was_nxt;
  logic               long_r,   long_nxt;
  logic [PRESS_W-1:0] press_r,  press_nxt;

  logic [DEAD_W-1:0]  since_inc;
  logic [PRESS_W-1:0] press_inc;
  logic [CNT_W:0]     cnt_inc;
  logic [PRE_W:0]     pre_inc;
  logic               sec_tick;
  logic               report;
  logic [CNT_W-1:0]   reported;

  always_comb begin
    was_nxt   = was_r;
    long_nxt  = long_r;
    press_nxt = press_r;
    run_nxt   = run_r;
    total_nxt = total_r;
    secs_nxt  = secs_r;
    report    = 1'b0;
    reported  = '0;
    press_inc = (press_r == '1) ? press_r : press_r + PRESS_W'(1);

    // button: press start, release toggle, long hold clear
    if (button_level && !was_r) begin
      was_nxt   = 1'b1;
      long_nxt  = 1'b0;
      press_nxt = '0;
    end else if (!button_level && was_r) begin
      was_nxt = 1'b0;
      if (!long_r) begin
        run_nxt = !run_r;
      end
    end else if (button_level && was_r && !long_r) begin
      press_nxt = press_inc;
      if (press_inc > cfg.long_press_ticks) begin
        long_nxt  = 1'b1;
        run_nxt   = 1'b0;
        secs_nxt  = '0;
        total_nxt = '0;
      end
    end

    // pulse edge with dead time
    since_inc = (since_r == '1) ? since_r : since_r + DEAD_W'(1);
    since_nxt = since_inc;
    cnt_inc   = {1'b0, total_nxt} + (CNT_W+1)'(1);
    if (pulse_rise && (since_inc > cfg.dead_time_ticks)) begin
      since_nxt = '0;
      if (run_nxt) begin
        total_nxt = (cnt_inc < {1'b0, cfg.count_limit}) ? cnt_inc[CNT_W-1:0]
                                                       : cfg.count_limit;
      end
    end

    // prescaler and gate
    pre_inc  = {1'b0, pre_r} + (PRE_W+1)'(1);
    sec_tick = (pre_inc >= {1'b0, cfg.ticks_per_second});
    pre_nxt  = sec_tick ? '0 : pre_inc[PRE_W-1:0];
    if (sec_tick && run_nxt) begin
      if (secs_nxt < SECONDS_MAX) begin
        secs_nxt = secs_nxt + SEC_W'(1);
      end
      if (secs_nxt >= cfg.gate_seconds) begin
        report    = 1'b1;
        reported  = total_nxt;
        total_nxt = '0;
        secs_nxt  = '0;
      end
    end
  end

  always_comb begin
    res.pulse_count   = total_nxt;
    res.seconds_shown = secs_nxt;
    res.is_running    = run_nxt;
    res.report_valid  = report;
    res.report_count  = reported;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= '1;
      total_r <= '0;
      run_r   <= 1'b0;
      pre_r   <= '0;
      secs_r  <= '0;
      was_r   <= 1'b0;
      long_r  <= 1'b0;
      press_r <= '0;
    end else if (advance) begin
      since_r <= since_nxt;
      total_r <= total_nxt;
      run_r   <= run_nxt;
      pre_r   <= pre_nxt;
      secs_r  <= secs_nxt;
      was_r   <= was_nxt;
      long_r  <= long_nxt;
      press_r <= press_nxt;
    end
  end

endmodule

@@ verif/tb_gated_pulse_counter_dead_time.sv @@
module tb_gated_pulse_counter_dead_time;
  timeunit 1ns;
  timeprecision 1ps;

  import gpc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 80;

  class window_tracker;
    logic [DEAD_W-1:0]  dead_time;
    logic [PRESS_W-1:0] long_press;
    logic [PRE_W-1:0]   tick_period;
    logic [SEC_W-1:0]   gate_len;
    logic [CNT_W-1:0]   limit;

    logic [DEAD_W-1:0]  since_edge;
    logic [CNT_W-1:0]   count;
    logic               running;
    logic [PRE_W-1:0]   prescale;
    logic [SEC_W-1:0]   seconds;
    logic               btn_held;
    logic               long_seen;
    logic [PRESS_W-1:0] press_ticks;

    res_t due_words[$];
    int   errors;

    function new();
      dead_time   = DEAD_TIME_RST;
      long_press  = LONG_PRESS_RST;
      tick_period = TPS_RST;
      gate_len    = GATE_RST;
      limit       = LIMIT_RST;
      since_edge  = '1;
      count       = '0;
      running     = 1'b0;
      prescale    = '0;
      seconds     = '0;
      btn_held    = 1'b0;
      long_seen   = 1'b0;
      press_ticks = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DW-1:0] v);
      case (idx)
        CFG_DEAD_TIME:  dead_time   = v[DEAD_W-1:0];
        CFG_LONG_PRESS: long_press  = v[PRESS_W-1:0];
        CFG_TPS:        tick_period = v[PRE_W-1:0];
        CFG_GATE:       gate_len    = v[SEC_W-1:0];
        CFG_LIMIT:      limit       = v[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit pulse, bit level);
      res_t              want;
      logic [CNT_W:0]    next_count;
      logic [PRE_W:0]    next_pre;
      want.report_valid = 1'b0;
      want.report_count = '0;

      if (level && !btn_held) begin
        btn_held    = 1'b1;
        long_seen   = 1'b0;
        press_ticks = '0;
      end else if (!level && btn_held) begin
        btn_held = 1'b0;
        if (!long_seen) running = !running;
      end else if (level && btn_held && !long_seen) begin
        if (press_ticks != '1) press_ticks = press_ticks + PRESS_W'(1);
        if (press_ticks > long_press) begin
          long_seen = 1'b1;
          running   = 1'b0;
          seconds   = '0;
          count     = '0;
        end
      end

      if (since_edge != '1) since_edge = since_edge + DEAD_W'(1);
      if (pulse && since_edge > dead_time) begin
        since_edge = '0;
        if (running) begin
          next_count = {1'b0, count} + (CNT_W+1)'(1);
          count = (next_count < {1'b0, limit}) ? next_count[CNT_W-1:0] : limit;
        end
      end

      next_pre = {1'b0, prescale} + (PRE_W+1)'(1);
      if (next_pre >= {1'b0, tick_period}) begin
        prescale = '0;
        if (running) begin
          if (seconds < SECONDS_MAX) seconds = seconds + SEC_W'(1);
          if (seconds >= gate_len) begin
            want.report_valid = 1'b1;
            want.report_count = count;
            count   = '0;
            seconds = '0;
          end
        end
      end else begin
        prescale = next_pre[PRE_W-1:0];
      end

      want.pulse_count   = count;
      want.seconds_shown = seconds;
      want.is_running    = running;
      due_words.push_back(want);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (due_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_words.pop_front();
      compare_field("pulse_count", want.pulse_count, got.pulse_count);
      compare_field("seconds_shown", CNT_W'(want.seconds_shown), CNT_W'(got.seconds_shown));
      compare_field("is_running", CNT_W'(want.is_running), CNT_W'(got.is_running));
      compare_field("report_valid", CNT_W'(want.report_valid), CNT_W'(got.report_valid));
      compare_field("report_count", want.report_count, got.report_count);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IDXW-1:0] cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;

  gpc_in_if  in_w();
  gpc_out_if out_w();

  window_tracker book = new();
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;
  int unsigned   idle_cycles = 0;

  gated_pulse_counter_dead_time dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_w),
    .out_word  (out_w),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_tick(bit pulse, bit level);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid        <= 1'b1;
    in_w.pulse_rise   <= pulse;
    in_w.button_level <= level;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    book.note_tick(pulse, level);
  endtask

  task automatic wait_drained();
    in_w.valid <= 1'b0;
    while (book.due_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_regs(logic [CFG_DW-1:0] vals [5]);
    cfg_idx_t order [5];
    order = '{CFG_DEAD_TIME, CFG_LONG_PRESS, CFG_TPS, CFG_GATE, CFG_LIMIT};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      book.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // press and release gestures with random pulses; some ticks carry a random level
  task automatic run_ticks(int n, int hold_at, int pause_at);
    int  sent;
    int  len;
    int  kind;
    bit  level;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) len = $urandom_range(1, 6);
      else if (kind < 8) len = $urandom_range(6, 16);
      else len = 0;
      for (int i = 0; i < len; i++) begin
        send_tick($urandom_range(0, 2) == 0, 1'b1);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
        if (sent == pause_at) wait_drained();
      end
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        level = (kind == 9) ? 1'($urandom_range(0, 1)) : 1'b0;
        send_tick($urandom_range(0, 2) == 0, level);
        sent++;
        if (sent == hold_at) hold_req = 1'b1;
        if (sent == pause_at) wait_drained();
      end
    end
  endtask

  initial begin
    logic [CFG_DW-1:0] regs [5];
    bit   [1:0]        directed [25];
    directed = '{2'b10, 2'b10, 2'b01, 2'b00, 2'b10, 2'b11, 2'b00, 2'b01, 2'b10,
                 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01,
                 2'b01, 2'b01, 2'b01, 2'b01, 2'b10, 2'b11, 2'b00};

    rst_n             <= 1'b0;
    in_w.valid        <= 1'b0;
    in_w.pulse_rise   <= 1'b0;
    in_w.button_level <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_DEAD_TIME;
    cfg_wdata         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    regs = '{24'd2, 24'd3, 24'd2, 24'd3, 24'd2};
    load_regs(regs);
    foreach (directed[i]) send_tick(directed[i][1], directed[i][0]);

    regs = '{24'd3, 24'd5, 24'd3, 24'd4, 24'd5};
    load_regs(regs);
    run_ticks(100, 40, -1);

    regs = '{24'd0, 24'd1, 24'd1, 24'd1, 24'd1};
    load_regs(regs);
    run_ticks(60, -1, -1);

    regs = '{24'd65535, 24'hFFFFFF, 24'hFFFFFF, 24'd999, 24'd65535};
    load_regs(regs);
    run_ticks(30, -1, -1);

    regs = '{24'd1, 24'd10, 24'd2, 24'd3, 24'd65535};
    load_regs(regs);
    run_ticks(60, -1, 30);

    repeat (3) begin
      regs = '{24'($urandom_range(0, 4)), 24'($urandom_range(1, 6)),
               24'($urandom_range(1, 5)), 24'($urandom_range(1, 6)),
               24'($urandom_range(1, 8))};
      load_regs(regs);
      run_ticks(50, -1, -1);
    end

    regs = '{24'd2, 24'd4, 24'd2, 24'd2, 24'd6};
    load_regs(regs);
    quiet = 1'b1;
    run_ticks(60, -1, -1);

    wait_drained();
    if (book.errors == 0 && book.due_words.size() == 0) begin
      $display("PASS gated_pulse_counter_dead_time");
    end else begin
      $display("FAIL gated_pulse_counter_dead_time");
    end
    $finish;
  end

  initial begin
    int   stall_left;
    res_t got;
    stall_left = 0;
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_w.valid && out_w.ready) begin
        got.pulse_count   = out_w.pulse_count;
        got.seconds_shown = out_w.seconds_shown;
        got.is_running    = out_w.is_running;
        got.report_valid  = out_w.report_valid;
        got.report_count  = out_w.report_count;
        book.check_word(got);
      end
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_w.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL gated_pulse_counter_dead_time");
    $finish;
  end

endmodule
